// ----- src/lrhs_pkg.sv -----
// Shared types, codes and reset values of the link reconnect and heartbeat supervisor.
package lrhs_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int APB_ADDR_WIDTH = 5;
    localparam int APB_DATA_WIDTH = 32;
    localparam int S_TDATA_WIDTH  = 40;
    localparam int M_TDATA_WIDTH  = 80;

    localparam logic [15:0] INIT_BACKOFF_RST = 16'd1;
    localparam logic [15:0] MAX_BACKOFF_RST  = 16'd60;
    localparam logic [15:0] HB_INTERVAL_RST  = 16'd30;
    localparam logic [7:0]  MAX_MISSED_RST   = 8'd3;
    localparam logic        CHECK_IN_RST     = 1'b1;

    localparam logic [15:0] RETRY_SAT = 16'hFFFF;
    localparam logic [7:0]  PING_SAT  = 8'hFF;

    typedef enum logic [2:0] {
        REG_INIT_BACKOFF = 3'd0,
        REG_MAX_BACKOFF  = 3'd1,
        REG_HB_INTERVAL  = 3'd2,
        REG_MAX_MISSED   = 3'd3,
        REG_CHECK_IN     = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_DATA = 2'd1,
        CMD_RX   = 2'd2,
        CMD_LOSS = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_CONN_FAIL = 3'd1,
        ACT_CONNECTED = 3'd2,
        ACT_PING      = 3'd3,
        ACT_DROPPED   = 3'd4,
        ACT_DATA_SENT = 3'd5,
        ACT_DATA_DOWN = 3'd6
    } action_t;

    typedef struct packed {
        logic [15:0] initial_backoff;
        logic [15:0] max_backoff;
        logic [15:0] heartbeat_interval;
        logic [7:0]  max_missed_pings;
        logic        check_inbound;
    } cfg_t;

endpackage

// ----- src/lrhs_cfg.sv -----
// APB configuration register file of the supervisor.
module lrhs_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lrhs_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [lrhs_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [lrhs_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                 pready,
    output lrhs_pkg::cfg_t                       cfg
);
    import lrhs_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_WIDTH-1:2]);
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_INIT_BACKOFF: cfg_next.initial_backoff    = pwdata[15:0];
                REG_MAX_BACKOFF:  cfg_next.max_backoff        = pwdata[15:0];
                REG_HB_INTERVAL:  cfg_next.heartbeat_interval = pwdata[15:0];
                REG_MAX_MISSED:   cfg_next.max_missed_pings   = pwdata[7:0];
                REG_CHECK_IN:     cfg_next.check_inbound      = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_INIT_BACKOFF: prdata = {16'd0, cfg_reg.initial_backoff};
            REG_MAX_BACKOFF:  prdata = {16'd0, cfg_reg.max_backoff};
            REG_HB_INTERVAL:  prdata = {16'd0, cfg_reg.heartbeat_interval};
            REG_MAX_MISSED:   prdata = {24'd0, cfg_reg.max_missed_pings};
            REG_CHECK_IN:     prdata = {31'd0, cfg_reg.check_inbound};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.initial_backoff    <= INIT_BACKOFF_RST;
            cfg_reg.max_backoff        <= MAX_BACKOFF_RST;
            cfg_reg.heartbeat_interval <= HB_INTERVAL_RST;
            cfg_reg.max_missed_pings   <= MAX_MISSED_RST;
            cfg_reg.check_inbound      <= CHECK_IN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/lrhs_engine.sv -----
// Link state update, result register and skid stage of the supervisor.
module lrhs_engine #(
    parameter int TIME_WIDTH = lrhs_pkg::TIME_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lrhs_pkg::cfg_t                      cfg,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // now_sec[31:0], connect_ok[32], send_ok[33], frame_ok[34], zero pad
    input  logic [lrhs_pkg::S_TDATA_WIDTH-1:0]  s_tdata,
    // cmd[1:0]
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // link_up[0], backoff_now[16:1], retry_count[32:17], pings_pending[40:33],
    // retry_at[72:41], zero pad
    output logic [lrhs_pkg::M_TDATA_WIDTH-1:0]  m_tdata,
    // action[2:0]
    output logic [2:0]                          m_tuser
);
    import lrhs_pkg::*;

    logic                    up_reg, up_next;
    logic [15:0]             backoff_reg, backoff_next;
    logic [TIME_WIDTH-1:0]   retry_reg, retry_next;
    logic [15:0]             fails_reg, fails_next;
    logic [TIME_WIDTH-1:0]   last_reg, last_next;
    logic [7:0]              pings_reg, pings_next;

    logic                    out_valid_reg, skid_valid_reg;
    logic [M_TDATA_WIDTH-1:0] out_data_reg, skid_data_reg;
    action_t                 out_act_reg, skid_act_reg;

    cmd_t                    cmd;
    logic [TIME_WIDTH-1:0]   now_t;
    logic                    connect_ok, send_ok, frame_ok;
    logic [TIME_WIDTH-1:0]   elapsed;
    logic [16:0]             dbl;
    logic [15:0]             grow;
    action_t                 act;
    logic [M_TDATA_WIDTH-1:0] res_data;
    logic                    accept, take;

    assign cmd        = cmd_t'(s_tuser);
    assign now_t      = TIME_WIDTH'(s_tdata[31:0]);
    assign connect_ok = s_tdata[32];
    assign send_ok    = s_tdata[33];
    assign frame_ok   = s_tdata[34];
    assign elapsed    = now_t - last_reg;
    assign dbl        = {backoff_reg, 1'b0};

    always_comb begin
        if (backoff_reg == 16'd0) begin
            grow = cfg.initial_backoff;
        end else if (dbl < {1'b0, cfg.max_backoff}) begin
            grow = dbl[15:0];
        end else begin
            grow = cfg.max_backoff;
        end
    end

    always_comb begin
        logic drop;
        drop         = 1'b0;
        act          = ACT_NONE;
        up_next      = up_reg;
        backoff_next = backoff_reg;
        retry_next   = retry_reg;
        fails_next   = fails_reg;
        last_next    = last_reg;
        pings_next   = pings_reg;
        unique case (cmd)
            CMD_TICK: begin
                if (up_reg) begin
                    if (cfg.heartbeat_interval != 16'd0 &&
                        elapsed >= TIME_WIDTH'(cfg.heartbeat_interval)) begin
                        if (pings_reg >= cfg.max_missed_pings || !send_ok) begin
                            drop = 1'b1;
                        end else begin
                            if (pings_reg != PING_SAT) begin
                                pings_next = pings_reg + 8'd1;
                            end
                            last_next = now_t;
                            act       = ACT_PING;
                        end
                    end
                end else if (now_t >= retry_reg) begin
                    if (!connect_ok) begin
                        if (fails_reg != RETRY_SAT) begin
                            fails_next = fails_reg + 16'd1;
                        end
                        backoff_next = grow;
                        retry_next   = now_t + TIME_WIDTH'(grow);
                        act          = ACT_CONN_FAIL;
                    end else begin
                        up_next      = 1'b1;
                        fails_next   = '0;
                        backoff_next = '0;
                        retry_next   = '0;
                        last_next    = now_t;
                        pings_next   = '0;
                        act          = ACT_CONNECTED;
                    end
                end
            end
            CMD_DATA: begin
                if (!up_reg) begin
                    act = ACT_DATA_DOWN;
                end else if (send_ok) begin
                    act = ACT_DATA_SENT;
                end else begin
                    drop = 1'b1;
                end
            end
            CMD_RX: begin
                pings_next = '0;
                if (cfg.check_inbound && !frame_ok) begin
                    drop = 1'b1;
                end
            end
            CMD_LOSS: begin
                if (up_reg) begin
                    drop = 1'b1;
                end
            end
        endcase
        if (drop) begin
            up_next      = 1'b0;
            backoff_next = '0;
            retry_next   = '0;
            pings_next   = '0;
            act          = ACT_DROPPED;
        end
    end

    assign res_data = {7'd0, 32'(retry_next), pings_next, fails_next, backoff_next, up_next};

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign take     = out_valid_reg && m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_act_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg         <= 1'b0;
            backoff_reg    <= '0;
            retry_reg      <= '0;
            fails_reg      <= '0;
            last_reg       <= '0;
            pings_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                up_reg      <= up_next;
                backoff_reg <= backoff_next;
                retry_reg   <= retry_next;
                fails_reg   <= fails_next;
                last_reg    <= last_next;
                pings_reg   <= pings_next;
            end
            if (take || !out_valid_reg) begin
                out_valid_reg  <= skid_valid_reg || accept;
                skid_valid_reg <= 1'b0;
            end else if (accept) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
                out_act_reg  <= skid_act_reg;
            end else begin
                out_data_reg <= res_data;
                out_act_reg  <= act;
            end
        end else if (accept) begin
            skid_data_reg <= res_data;
            skid_act_reg  <= act;
        end
    end

    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a beat while the result register is empty");

    a_down_no_pings: assert property (@(posedge aclk) disable iff (!aresetn)
        !up_reg |-> pings_reg == 8'd0)
        else $error("unanswered pings counted while link is down");

    a_up_no_backoff: assert property (@(posedge aclk) disable iff (!aresetn)
        up_reg |-> (backoff_reg == 16'd0 && retry_reg == '0))
        else $error("backoff state not cleared while link is up");

    a_connect_sets_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && act == ACT_CONNECTED) |=> up_reg)
        else $error("connect did not raise the link");

    a_drop_clears_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && act == ACT_DROPPED) |=> !up_reg)
        else $error("drop left the link up");

endmodule

// ----- src/link_reconnect_heartbeat_supervisor_core.sv -----
// Top level of the link reconnect and heartbeat supervisor.
// Results are registered: an accepted beat's result enters the result register, or the skid stage.
// Throughput: one beat per cycle while s_tready is high; state update is one compare, add and doubling pass.
// A result register and a one-beat skid stage absorb one beat while m_tready is low;
// s_tready drops while the skid stage holds a beat.
// Reset: aresetn low clears link state and the output stages and loads register defaults.
module link_reconnect_heartbeat_supervisor_core #(
    parameter int TIME_WIDTH = lrhs_pkg::TIME_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lrhs_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [lrhs_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [lrhs_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                 pready,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // now_sec[31:0], connect_ok[32], send_ok[33], frame_ok[34], zero pad
    input  logic [lrhs_pkg::S_TDATA_WIDTH-1:0]   s_tdata,
    // cmd[1:0]
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // link_up[0], backoff_now[16:1], retry_count[32:17], pings_pending[40:33],
    // retry_at[72:41], zero pad
    output logic [lrhs_pkg::M_TDATA_WIDTH-1:0]   m_tdata,
    // action[2:0]
    output logic [2:0]                           m_tuser
);
    import lrhs_pkg::*;

    cfg_t cfg;

    lrhs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lrhs_engine #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
